// ===== src/gcr62_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gcr62_pkg;

  localparam int BufDepth = 256;
  localparam int BufAddrW = 8;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_VOLUME     = 2'd0;
  localparam logic [1:0] REG_TRACK_GAP  = 2'd1;
  localparam logic [1:0] REG_DATA_SYNC  = 2'd2;
  localparam logic [1:0] REG_SECTOR_GAP = 2'd3;

  localparam logic [7:0] VOLUME_RST     = 8'd254;
  localparam logic [7:0] TRACK_GAP_RST  = 8'd48;
  localparam logic [7:0] DATA_SYNC_RST  = 8'd6;
  localparam logic [7:0] SECTOR_GAP_RST = 8'd27;

  // stream parts in order
  localparam logic [2:0] PART_TRACK_GAP  = 3'd0;
  localparam logic [2:0] PART_ADDRESS    = 3'd1;
  localparam logic [2:0] PART_PROLOGUE   = 3'd2;
  localparam logic [2:0] PART_DATA_SYNC  = 3'd3;
  localparam logic [2:0] PART_DATA       = 3'd4;
  localparam logic [2:0] PART_EPILOGUE   = 3'd5;
  localparam logic [2:0] PART_SECTOR_GAP = 3'd6;
  localparam logic [2:0] PART_DONE       = 3'd7;

  localparam logic [9:0] ADDRESS_LEN   = 10'd14;
  localparam logic [9:0] MARK_LEN      = 10'd3;
  localparam logic [9:0] DATA_LEN      = 10'd343;
  localparam logic [9:0] DATA_VALUES   = 10'd342;
  localparam logic [9:0] TWO_BIT_VALS  = 10'd86;
  localparam logic [9:0] CLEAR_TOP_POS = 10'd84;
  localparam logic [7:0] OFFSET_MID    = 8'h56;
  localparam logic [7:0] OFFSET_HIGH   = 8'hAC;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] MARK_D5   = 8'hD5;
  localparam logic [7:0] MARK_AA   = 8'hAA;
  localparam logic [7:0] MARK_96   = 8'h96;
  localparam logic [7:0] MARK_AD   = 8'hAD;
  localparam logic [7:0] MARK_DE   = 8'hDE;
  localparam logic [7:0] MARK_EB   = 8'hEB;
  localparam logic [7:0] ODD_MASK  = 8'h55;
  localparam logic [7:0] FILL_MASK = 8'hAA;

  // buffer read address selection
  localparam logic [1:0] RD_K     = 2'd0;
  localparam logic [1:0] RD_K_MID = 2'd1;
  localparam logic [1:0] RD_K_HI  = 2'd2;
  localparam logic [1:0] RD_K_LOW = 2'd3;

  localparam logic [7:0] GCR_TABLE [0:63] = '{
    8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
    8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
    8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
    8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
    8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
    8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
    8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
    8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
  };

  function automatic logic [7:0] gcr_encode(input logic [5:0] v);
    return GCR_TABLE[v];
  endfunction

  function automatic logic [1:0] rev2(input logic [7:0] b);
    return {b[0], b[1]};
  endfunction

  function automatic logic [7:0] four_and_four(input logic [7:0] v, input logic second);
    logic [7:0] s;
    s = second ? v : (v >> 1);
    return (s & ODD_MASK) | FILL_MASK;
  endfunction

  typedef struct packed {
    logic       load_wr;
    logic       skip_adv;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_slot;
    logic       step;
    logic       out_ld;
    logic       out_refused;
  } cmd_t;

  typedef struct packed {
    logic loaded;
    logic part_empty;
    logic need_triple;
    logic need_single;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/gcr62_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcr62_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/gcr62_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcr62_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  gcr62_pkg::cmd_t   cmd,
  output gcr62_pkg::sts_t   sts,
  input  logic [7:0]        in_data_byte,
  input  logic [7:0]        in_track,
  input  logic [3:0]        in_sector,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_nibble,
  output logic              out_last,
  output logic              out_refused,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata
);
  import gcr62_pkg::*;

  logic [7:0] volume_r, track_gap_r, data_sync_r, sector_gap_r;
  logic [8:0] load_count_r;
  logic [9:0] pos_r;
  logic [2:0] part_r;
  logic [5:0] prev_r;
  logic [7:0] held_track_r;
  logic [3:0] held_sector_r;
  logic [7:0] slot_r [3];
  logic [7:0] nib_r;
  logic       out_valid_r;
  logic [7:0] out_nibble_r;
  logic       out_last_r;
  logic       out_refused_r;

  logic [9:0]          part_len;
  logic [BufAddrW-1:0] raddr;
  logic [7:0]          rdata;
  logic                buf_we;
  logic [7:0]          reg_rd;
  logic [7:0]          nib_calc;
  logic [5:0]          cur6;
  logic [5:0]          prev6;
  logic [3:0]          apos;
  logic [3:0]          fidx;
  logic [7:0]          field_v;
  logic                cfg_wr;
  logic                clear_stream;

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r     <= VOLUME_RST;
      track_gap_r  <= TRACK_GAP_RST;
      data_sync_r  <= DATA_SYNC_RST;
      sector_gap_r <= SECTOR_GAP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_VOLUME:    volume_r     <= pwdata[7:0];
        REG_TRACK_GAP: track_gap_r  <= pwdata[7:0];
        REG_DATA_SYNC: data_sync_r  <= pwdata[7:0];
        default:       sector_gap_r <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VOLUME:    reg_rd = volume_r;
      REG_TRACK_GAP: reg_rd = track_gap_r;
      REG_DATA_SYNC: reg_rd = data_sync_r;
      default:       reg_rd = sector_gap_r;
    endcase
  end
  assign prdata = {24'd0, reg_rd};

  // sector buffer
  assign buf_we = cmd.load_wr && !load_count_r[8];

  always_comb begin
    case (cmd.rd_sel)
      RD_K:     raddr = pos_r[7:0];
      RD_K_MID: raddr = pos_r[7:0] + OFFSET_MID;
      RD_K_HI:  raddr = pos_r[7:0] + OFFSET_HIGH;
      default:  raddr = pos_r[7:0] - TWO_BIT_VALS[7:0];
    endcase
  end

  gcr62_ram #(
    .WIDTH(8),
    .DEPTH(BufDepth)
  ) u_buf (
    .clk  (clk),
    .we   (buf_we),
    .waddr(load_count_r[BufAddrW-1:0]),
    .wdata(in_data_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    case (part_r)
      PART_TRACK_GAP:  part_len = (held_sector_r == 4'd0) ? {2'd0, track_gap_r} : 10'd0;
      PART_ADDRESS:    part_len = ADDRESS_LEN;
      PART_PROLOGUE:   part_len = MARK_LEN;
      PART_DATA_SYNC:  part_len = {2'd0, data_sync_r};
      PART_DATA:       part_len = DATA_LEN;
      PART_EPILOGUE:   part_len = MARK_LEN;
      PART_SECTOR_GAP: part_len = {2'd0, sector_gap_r};
      default:         part_len = 10'd0;
    endcase
  end

  // six-and-two value for the current data position
  always_comb begin
    if (pos_r < TWO_BIT_VALS) begin
      cur6 = {(pos_r >= CLEAR_TOP_POS) ? 2'd0 : rev2(slot_r[2]),
              rev2(slot_r[1]), rev2(slot_r[0])};
    end else begin
      cur6 = slot_r[0][7:2];
    end
    prev6 = (pos_r == 10'd0) ? 6'd0 : prev_r;
  end

  assign apos = pos_r[3:0];
  assign fidx = apos - 4'd3;

  always_comb begin
    case (fidx[2:1])
      2'd0:    field_v = volume_r;
      2'd1:    field_v = held_track_r;
      2'd2:    field_v = {4'd0, held_sector_r};
      default: field_v = volume_r ^ held_track_r ^ {4'd0, held_sector_r};
    endcase
  end

  always_comb begin
    nib_calc = SYNC_BYTE;
    case (part_r)
      PART_ADDRESS: begin
        if (apos == 4'd0) nib_calc = MARK_D5;
        else if (apos == 4'd1) nib_calc = MARK_AA;
        else if (apos == 4'd2) nib_calc = MARK_96;
        else if (apos == 4'd11) nib_calc = MARK_DE;
        else if (apos == 4'd12) nib_calc = MARK_AA;
        else if (apos == 4'd13) nib_calc = MARK_EB;
        else nib_calc = four_and_four(field_v, fidx[0]);
      end
      PART_PROLOGUE: begin
        case (pos_r[1:0])
          2'd0:    nib_calc = MARK_D5;
          2'd1:    nib_calc = MARK_AA;
          default: nib_calc = MARK_AD;
        endcase
      end
      PART_DATA: begin
        if (pos_r >= DATA_VALUES) nib_calc = gcr_encode(prev6);
        else nib_calc = gcr_encode(cur6 ^ prev6);
      end
      PART_EPILOGUE: begin
        case (pos_r[1:0])
          2'd0:    nib_calc = MARK_DE;
          2'd1:    nib_calc = MARK_AA;
          default: nib_calc = MARK_EB;
        endcase
      end
      default: nib_calc = SYNC_BYTE;
    endcase
  end

  assign clear_stream = cmd.out_ld && !cmd.out_refused && (part_r == PART_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r  <= 9'd0;
      pos_r         <= 10'd0;
      part_r        <= PART_TRACK_GAP;
      prev_r        <= 6'd0;
      held_track_r  <= 8'd0;
      held_sector_r <= 4'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (buf_we) begin
        if (load_count_r == 9'd0) begin
          held_track_r  <= in_track;
          held_sector_r <= in_sector;
        end
        load_count_r <= load_count_r + 9'd1;
      end
      if (cmd.skip_adv) begin
        part_r <= part_r + 3'd1;
        pos_r  <= 10'd0;
      end
      if (cmd.step) begin
        pos_r <= pos_r + 10'd1;
        if (part_r == PART_DATA && pos_r < DATA_VALUES) begin
          prev_r <= cur6;
        end
      end
      if (clear_stream) begin
        load_count_r <= 9'd0;
        part_r       <= PART_TRACK_GAP;
        pos_r        <= 10'd0;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      slot_r[cmd.cap_slot] <= rdata;
    end
    if (cmd.step) begin
      nib_r <= nib_calc;
    end
    if (cmd.out_ld) begin
      out_nibble_r  <= cmd.out_refused ? 8'd0 : nib_r;
      out_last_r    <= !cmd.out_refused && (part_r == PART_DONE);
      out_refused_r <= cmd.out_refused;
    end
  end

  always_comb begin
    sts.loaded      = load_count_r[8];
    sts.part_empty  = (part_r != PART_DONE) && (pos_r >= part_len);
    sts.need_triple = (part_r == PART_DATA) && (pos_r < TWO_BIT_VALS);
    sts.need_single = (part_r == PART_DATA) && (pos_r >= TWO_BIT_VALS)
                      && (pos_r < DATA_VALUES);
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid   = out_valid_r;
  assign out_nibble  = out_nibble_r;
  assign out_last    = out_last_r;
  assign out_refused = out_refused_r;

endmodule

`default_nettype wire

// ===== src/gcr62_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcr62_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_func,
  output logic            in_stall,
  output gcr62_pkg::cmd_t cmd,
  input  gcr62_pkg::sts_t sts
);
  import gcr62_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RDW,
    ST_STEP,
    ST_POST,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   refuse_r, refuse_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    refuse_nxt = refuse_r;
    cmd        = '0;
    cmd.rd_sel = RD_K;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_LOAD) begin
            cmd.load_wr = 1'b1;
          end else if (sts.loaded) begin
            state_nxt = ST_PRE;
          end else begin
            refuse_nxt = 1'b1;
            state_nxt  = ST_RESP;
          end
        end
      end
      ST_PRE: begin
        // walk past empty parts, then fetch buffer bytes if needed
        if (sts.part_empty) begin
          cmd.skip_adv = 1'b1;
        end else if (sts.need_triple) begin
          cmd.rd_sel = RD_K;
          state_nxt  = ST_RD1;
        end else if (sts.need_single) begin
          cmd.rd_sel = RD_K_LOW;
          state_nxt  = ST_RDW;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_RD1: begin
        cmd.rd_sel   = RD_K_MID;
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = 2'd0;
        state_nxt    = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_sel   = RD_K_HI;
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = 2'd1;
        state_nxt    = ST_RD3;
      end
      ST_RD3: begin
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = 2'd2;
        state_nxt    = ST_STEP;
      end
      ST_RDW: begin
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = 2'd0;
        state_nxt    = ST_STEP;
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_POST;
      end
      ST_POST: begin
        if (sts.part_empty) begin
          cmd.skip_adv = 1'b1;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_ld      = 1'b1;
          cmd.out_refused = refuse_r;
          refuse_nxt      = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      refuse_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      refuse_r <= refuse_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/gcr62_sector_nibble_encoder_unit.sv =====
// 6-and-2 GCR sector nibble encoder.
// Input channel (in_valid/in_stall): in_func = 0 loads one sector data byte,
// in order; track and sector are taken with byte 0. in_func = 1 asks for
// the next disk nibble of the sector stream. Loads give no word; loads are
// dropped once 256 bytes are held until the stream ends.
// Output channel (out_valid/out_stall): one word per emit. An emit before
// the sector is fully loaded returns out_refused = 1 with nibble 0.
// out_last marks the final byte of the stream; the next loads start a new
// sector.
// Emit steps: walk past empty parts, then three buffer reads through the
// single read port for the first 86 data nibbles or one read for the rest
// of the data field, then step, walk past empty parts and place the word.
// A refused emit goes straight to placing its word.
// Stalls: the output register holds its word; loads keep being accepted while
// no emit waits, and an emit waits (stalling the input) for the register to drain.
// Reset (rst_n, synchronous): registers return to defaults (volume 254,
// gaps 48/6/27) and load count clears; buffer contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module gcr62_sector_nibble_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_track,
  input  logic [3:0]  in_sector,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_nibble,
  output logic        out_last,
  output logic        out_refused,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gcr62_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  gcr62_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_func (in_func),
    .in_stall(in_stall),
    .cmd     (cmd),
    .sts     (sts)
  );

  gcr62_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data_byte(in_data_byte),
    .in_track    (in_track),
    .in_sector   (in_sector),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_nibble  (out_nibble),
    .out_last    (out_last),
    .out_refused (out_refused),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

  // output register is only loaded when it is empty or draining
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("output word overwritten while held");

  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_refused) |-> (out_nibble == 8'd0 && !out_last))
    else $error("refused word carries data");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_ld))
    else $error("output word appeared without a load");

endmodule

`default_nettype wire
